### rtl/etf_pkg.sv
package etf_pkg;

	localparam logic [7:0] ITER_RESET = 8'd255;

	typedef struct packed {
		logic signed [31:0] cr;
		logic signed [31:0] ci;
		logic               skip;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	function automatic rgb_t palette(input logic [3:0] idx);
		rgb_t c;
		unique case (idx)
			4'd0:  c = '{8'd9,   8'd1,   8'd47};
			4'd1:  c = '{8'd4,   8'd4,   8'd73};
			4'd2:  c = '{8'd0,   8'd7,   8'd100};
			4'd3:  c = '{8'd12,  8'd44,  8'd138};
			4'd4:  c = '{8'd24,  8'd82,  8'd177};
			4'd5:  c = '{8'd57,  8'd125, 8'd209};
			4'd6:  c = '{8'd134, 8'd181, 8'd229};
			4'd7:  c = '{8'd211, 8'd236, 8'd248};
			4'd8:  c = '{8'd241, 8'd233, 8'd191};
			4'd9:  c = '{8'd248, 8'd201, 8'd95};
			4'd10: c = '{8'd255, 8'd170, 8'd0};
			4'd11: c = '{8'd204, 8'd128, 8'd0};
			4'd12: c = '{8'd153, 8'd87,  8'd0};
			4'd13: c = '{8'd106, 8'd52,  8'd3};
			4'd14: c = '{8'd66,  8'd30,  8'd15};
			4'd15: c = '{8'd25,  8'd7,   8'd26};
		endcase
		return c;
	endfunction

endpackage

### rtl/escape_time_fractal_pixel_unit.sv
// Round time is set by the 16-bit-digit multipliers.
// Throughput: one pixel at a time in the iteration loop; a 2-entry queue takes input
// while a pixel runs and the output register holds a result until transferred.
// Reset (arst_n low, async): queue and output empty, iteration limit back to 255.
module escape_time_fractal_pixel_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] coord_real,
	input  logic signed [31:0] coord_imag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         iteration_count,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	logic [7:0]       max_q;
	etf_pkg::q_head_t head;
	logic             pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= etf_pkg::ITER_RESET;
		end else if (cfg_valid) begin
			max_q <= cfg_data;
		end
	end

	etf_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.coord_real(coord_real), .coord_imag(coord_imag), .iter_limit(max_q),
		.head(head), .pop(pop)
	);

	etf_core #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .iter_limit(max_q), .head(head), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.iteration_count(iteration_count), .red(red), .green(green), .blue(blue)
	);

endmodule

### rtl/etf_front.sv
module etf_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [31:0]     coord_real,
	input  logic signed [31:0]     coord_imag,
	input  logic [7:0]             iter_limit,
	output etf_pkg::q_head_t       head,
	input  logic                   pop
);

	etf_pkg::item_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign in_ready   = (cnt_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// zero limit: no round runs, pixel goes straight out black
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q].cr   <= coord_real;
			mem_q[wr_q].ci   <= coord_imag;
			mem_q[wr_q].skip <= (iter_limit == 8'd0);
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != 2'd0))
		else $error("pop from empty queue");

endmodule

### rtl/etf_mul.sv
module etf_mul #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] p
);

	localparam int DIGIT = 16;
	localparam int ND    = (WORD_BITS + DIGIT - 1) / DIGIT;
	localparam int BW    = ND * DIGIT;
	localparam int HW    = WORD_BITS + DIGIT + 2;
	localparam int PW    = HW + BW;
	localparam int EW    = (FRAC_BITS + WORD_BITS > PW) ? FRAC_BITS + WORD_BITS : PW;
	localparam int CW    = (ND > 1) ? $clog2(ND) : 1;

	logic signed [WORD_BITS-1:0]     a_q;
	logic [BW-1:0]                   b_q;
	logic signed [HW-1:0]            h_q;
	logic [BW-1:0]                   l_q;
	logic [CW-1:0]                   cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic                            last_step;
	logic signed [DIGIT:0]           dig;
	logic signed [WORD_BITS+DIGIT:0] prod;
	logic signed [HW-1:0]            t;
	logic signed [EW-1:0]            full;

	// radix 2^16, low digit first; top digit carries the sign of b
	always_comb begin
		last_step = (cnt_q == CW'(ND - 1));
		dig  = last_step ? $signed({b_q[DIGIT-1], b_q[DIGIT-1:0]})
		                 : $signed({1'b0, b_q[DIGIT-1:0]});
		prod = a_q * dig;
		t    = h_q + HW'(prod);
		full = EW'($signed({h_q, l_q}));
	end

	assign p    = full[FRAC_BITS+WORD_BITS-1:FRAC_BITS];
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (last_step) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= BW'(b);
			h_q <= '0;
			l_q <= '0;
		end else if (busy_q) begin
			h_q <= t >>> DIGIT;
			l_q <= BW'({t[DIGIT-1:0], l_q} >> DIGIT);
			b_q <= b_q >> DIGIT;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiply started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $fell(busy_q))
		else $error("done without a finished digit sweep");

endmodule

### rtl/etf_core.sv
module etf_core #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             iter_limit,
	input  etf_pkg::q_head_t       head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             iteration_count,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue
);

	localparam logic [63:0] FOUR_WIDE = 64'd4 << FRAC_BITS;
	localparam logic signed [WORD_BITS-1:0] FOUR = FOUR_WIDE[WORD_BITS-1:0];

	typedef enum logic [2:0] {S_IDLE, S_GO, S_M1, S_M2, S_OUT} state_t;

	state_t                      state_q;
	logic signed [WORD_BITS-1:0] x_q, y_q, x2_q, y2_q, cr_q, ci_q;
	logic [7:0]                  it_q;
	logic                        black_q;
	logic                        out_valid_q;
	logic [7:0]                  count_q;
	etf_pkg::rgb_t               rgb_q;

	logic signed [WORD_BITS-1:0] xn, ynew, ssum, a0, b0, p0, p1;
	logic                        esc, last, start0, start1, done0, done1, out_free;

	always_comb begin
		xn       = x2_q - y2_q + cr_q;
		ynew     = p0 + ci_q;
		ssum     = x2_q + p0;
		esc      = ssum > FOUR;
		last     = (8'(it_q + 8'd1) == iter_limit);
		start0   = (state_q == S_GO) || ((state_q == S_M1) && done0);
		start1   = (state_q == S_GO);
		a0       = (state_q == S_GO) ? x_q + x_q : ynew;
		b0       = (state_q == S_GO) ? y_q : ynew;
		out_free = !out_valid_q || out_ready;
		pop      = (state_q == S_IDLE) && head.valid;
	end

	etf_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul0 (
		.clk(clk), .arst_n(arst_n), .start(start0), .a(a0), .b(b0),
		.done(done0), .p(p0)
	);

	etf_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul1 (
		.clk(clk), .arst_n(arst_n), .start(start1), .a(xn), .b(xn),
		.done(done1), .p(p1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						cr_q    <= WORD_BITS'(head.item.cr);
						ci_q    <= WORD_BITS'(head.item.ci);
						x_q     <= '0;
						y_q     <= '0;
						x2_q    <= '0;
						y2_q    <= '0;
						it_q    <= 8'd0;
						black_q <= 1'b1;
						state_q <= head.item.skip ? S_OUT : S_GO;
					end
				end
				S_GO: begin
					x_q     <= xn;
					state_q <= S_M1;
				end
				S_M1: begin
					if (done0) begin
						y_q     <= ynew;
						x2_q    <= p1;
						state_q <= S_M2;
					end
				end
				S_M2: begin
					if (done0) begin
						y2_q <= p0;
						if (esc) begin
							black_q <= 1'b0;
							state_q <= S_OUT;
						end else if (last) begin
							it_q    <= 8'(it_q + 8'd1);
							black_q <= 1'b1;
							state_q <= S_OUT;
						end else begin
							it_q    <= 8'(it_q + 8'd1);
							state_q <= S_GO;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						count_q     <= it_q;
						rgb_q       <= black_q ? '0 : etf_pkg::palette(it_q[3:0]);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign iteration_count = count_q;
	assign red             = rgb_q.r;
	assign green           = rgb_q.g;
	assign blue            = rgb_q.b;

	a_count_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (count_q <= iter_limit))
		else $error("count beyond limit");

	a_black_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((count_q == iter_limit) == (rgb_q == '0)))
		else $error("color does not match limit state");

	a_units_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_M1) |-> (done0 == done1))
		else $error("multipliers out of step");

endmodule
